[rtl/wpa_pkg.sv]
package wpa_pkg;

	localparam int MAX_PHASES_DEF = 8;
	localparam int LANES_DEF      = 4;

	localparam int TIME_W     = 32;
	localparam int AGE_W      = 24;
	localparam int QUEUE_W    = 8;
	localparam int WAIT_W     = 16;
	localparam int WEIGHT_W   = 16;
	localparam int PIN_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_PH_W   = 3;
	localparam int SCORE_W    = 42;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic [PIN_W-1:0]    PHASES_RST   = 4'd8;
	localparam logic [WEIGHT_W-1:0] DURATION_RST = 16'd10;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 16'd256;

	localparam logic OP_TIME = 1'b0;
	localparam logic OP_LANE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASES    = 3'd0,
		REG_DURATION  = 3'd1,
		REG_QUEUE_WT  = 3'd2,
		REG_WAIT_WT   = 3'd3,
		REG_AGING_WT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_AGE_RD = 7'b0000010,
		ST_AGE_WR = 7'b0000100,
		ST_SCORE  = 7'b0001000,
		ST_DRAIN  = 7'b0010000,
		ST_FINISH = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic vld;
		logic is_age;
		logic final_ph;
	} score_tag_t;

endpackage

[rtl/wpa_score.sv]
module wpa_score #(
	parameter int MAX_PHASES      = wpa_pkg::MAX_PHASES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wpa_pkg::score_tag_t                 tag_s1,
	input  logic [$clog2(MAX_PHASES)-1:0]       ph_s1,
	input  logic [wpa_pkg::QUEUE_W-1:0]         queue_s1,
	input  logic [wpa_pkg::WAIT_W-1:0]          wait_s1,
	input  logic [wpa_pkg::AGE_W-1:0]           age_s1,
	input  logic [wpa_pkg::WEIGHT_W-1:0]        queue_wt,
	input  logic [wpa_pkg::WEIGHT_W-1:0]        wait_wt,
	input  logic [wpa_pkg::WEIGHT_W-1:0]        aging_wt,
	output logic [$clog2(MAX_PHASES)-1:0]       best_ph,
	output logic                                done
);

	localparam int PH_W = $clog2(MAX_PHASES);
	localparam int PA_W = wpa_pkg::WEIGHT_W + wpa_pkg::QUEUE_W;
	localparam int PB_W = wpa_pkg::WEIGHT_W + wpa_pkg::AGE_W;

	wpa_pkg::score_tag_t             tag_s2;
	logic [PH_W-1:0]                 ph_s2;
	logic [PA_W-1:0]                 pa_s2;
	logic [PB_W-1:0]                 pb_s2;
	logic [wpa_pkg::WEIGHT_W-1:0]    mul_a;
	logic [wpa_pkg::AGE_W-1:0]       mul_b;
	logic [wpa_pkg::SCORE_W-1:0]     acc_q;
	logic [wpa_pkg::SCORE_W-1:0]     best_q;
	logic [PH_W-1:0]                 best_ph_q;
	logic [wpa_pkg::SCORE_W-1:0]     sum;

	assign mul_a = tag_s1.is_age ? aging_wt : wait_wt;
	assign mul_b = tag_s1.is_age ? age_s1 : wpa_pkg::AGE_W'(wait_s1);

	always_ff @(posedge clk) begin
		ph_s2 <= ph_s1;
		pa_s2 <= tag_s1.is_age ? '0 : PA_W'(queue_wt * queue_s1);
		pb_s2 <= PB_W'(mul_a * mul_b);
	end

	assign sum = acc_q + wpa_pkg::SCORE_W'(pa_s2) + wpa_pkg::SCORE_W'(pb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2    <= '0;
			acc_q     <= '0;
			best_q    <= '0;
			best_ph_q <= '0;
		end else begin
			tag_s2 <= tag_s1;
			if (tag_s2.vld) begin
				if (tag_s2.is_age) begin
					acc_q <= '0;
					if (ph_s2 == '0 || sum > best_q) begin
						best_q    <= sum;
						best_ph_q <= ph_s2;
					end
				end else begin
					acc_q <= sum;
				end
			end
		end
	end

	assign best_ph = best_ph_q;
	assign done    = tag_s2.vld && tag_s2.final_ph;

endmodule

[rtl/weighted_phase_auction_with_aging_core.sv]
// Lane report: the beat goes to ST_DONE, which loads the output register once it is free.
// Time item: the AGE_RD/AGE_WR states age all MAX_PHASES phases; if a decision is
//   due, SCORE reads each active phase's lanes and age, then DRAIN and FINISH run.
// One item at a time: the lane and age memories each serve one access a cycle.
// The next beat is taken once the result sits in the output register.
// arst_n clears state, lane and age valid bits, phase and times at once.
module weighted_phase_auction_with_aging_core #(
	parameter int MAX_PHASES      = wpa_pkg::MAX_PHASES_DEF,
	parameter int LANES_PER_PHASE = wpa_pkg::LANES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wpa_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [wpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sim_time, phase_index, lane_slot, queue_count, wait_seconds
	input  logic [63:0]                        s_tdata,
	// op
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// current_phase, switched, decided
	output logic [7:0]                         m_tdata
);

	localparam int PH_W    = $clog2(MAX_PHASES);
	localparam int CNT_W   = $clog2(MAX_PHASES + 1);
	localparam int LANE_N  = MAX_PHASES * LANES_PER_PHASE;
	localparam int LA_W    = $clog2(LANE_N);
	localparam int SL_W    = $clog2(LANES_PER_PHASE + 1);
	localparam int LANE_DW = wpa_pkg::QUEUE_W + wpa_pkg::WAIT_W;

	logic                            in_op;
	logic [wpa_pkg::TIME_W-1:0]      in_time;
	logic [2:0]                      in_ph;
	logic [1:0]                      in_slot;
	logic [wpa_pkg::QUEUE_W-1:0]     in_queue;
	logic [wpa_pkg::WAIT_W-1:0]      in_wait;

	logic [wpa_pkg::PIN_W-1:0]       pin_q;
	logic [wpa_pkg::WEIGHT_W-1:0]    dur_q;
	logic [wpa_pkg::WEIGHT_W-1:0]    qw_q;
	logic [wpa_pkg::WEIGHT_W-1:0]    ww_q;
	logic [wpa_pkg::WEIGHT_W-1:0]    aw_q;

	wpa_pkg::state_t                 state_q;
	logic [PH_W-1:0]                 ph_q;
	logic [SL_W-1:0]                 sl_q;
	logic [PH_W-1:0]                 act_q;
	logic [wpa_pkg::TIME_W-1:0]      now_q;
	logic [wpa_pkg::TIME_W-1:0]      age_dt_q;
	logic [wpa_pkg::TIME_W-1:0]      last_age_q;
	logic [wpa_pkg::TIME_W-1:0]      last_dec_q;
	logic [wpa_pkg::TIME_W-1:0]      elapsed;
	logic                            decide_q;
	logic                            switched_q;
	logic                            decided_q;
	logic                            m_tvalid_q;
	logic [7:0]                      m_tdata_q;

	logic [CNT_W-1:0]                eff_n;
	logic [PH_W-1:0]                 last_ph;
	logic                            acc_in;
	logic                            sl_end;

	logic [LANE_DW-1:0]              lane_mem [LANE_N];
	logic [LANE_N-1:0]               lane_vld_q;
	logic [LANE_DW-1:0]              lane_rdata_q;
	logic                            lane_rvld_q;
	logic                            lane_ok;
	logic                            lane_we;
	logic [LA_W-1:0]                 lane_wa;
	logic                            lane_re;
	logic [LA_W-1:0]                 lane_ra;

	logic [wpa_pkg::AGE_W-1:0]       age_mem [MAX_PHASES];
	logic [MAX_PHASES-1:0]           age_vld_q;
	logic [wpa_pkg::AGE_W-1:0]       age_rdata_q;
	logic                            age_rvld_q;
	logic                            age_re;
	logic                            age_we;
	logic [PH_W-1:0]                 age_wa;
	logic [wpa_pkg::AGE_W-1:0]       age_wd;
	logic [wpa_pkg::AGE_W-1:0]       age_cur;
	logic [wpa_pkg::TIME_W:0]        age_sum;
	logic [wpa_pkg::AGE_W-1:0]       aged;

	wpa_pkg::score_tag_t             tag_s1;
	logic [PH_W-1:0]                 ph_s1;
	logic [PH_W-1:0]                 best_ph;
	logic                            score_done;
	logic [wpa_pkg::QUEUE_W-1:0]     queue_s1;
	logic [wpa_pkg::WAIT_W-1:0]      wait_s1;

	assign in_op    = s_tuser[0];
	assign in_time  = s_tdata[31:0];
	assign in_ph    = s_tdata[34:32];
	assign in_slot  = s_tdata[36:35];
	assign in_queue = s_tdata[44:37];
	assign in_wait  = s_tdata[60:45];

	assign s_tready = (state_q == wpa_pkg::ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q <= wpa_pkg::PHASES_RST;
			dur_q <= wpa_pkg::DURATION_RST;
			qw_q  <= wpa_pkg::WEIGHT_RST;
			ww_q  <= wpa_pkg::WEIGHT_RST;
			aw_q  <= wpa_pkg::WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				wpa_pkg::REG_PHASES:   pin_q <= cfg_wdata[wpa_pkg::PIN_W-1:0];
				wpa_pkg::REG_DURATION: dur_q <= cfg_wdata;
				wpa_pkg::REG_QUEUE_WT: qw_q  <= cfg_wdata;
				wpa_pkg::REG_WAIT_WT:  ww_q  <= cfg_wdata;
				wpa_pkg::REG_AGING_WT: aw_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pin_q == '0) begin
			eff_n = CNT_W'(1);
		end else if (32'(pin_q) > MAX_PHASES) begin
			eff_n = CNT_W'(MAX_PHASES);
		end else begin
			eff_n = CNT_W'(pin_q);
		end
	end

	assign last_ph = PH_W'(eff_n - CNT_W'(1));
	assign sl_end  = (sl_q == SL_W'(LANES_PER_PHASE));
	assign elapsed = (in_time >= last_dec_q) ? in_time - last_dec_q : '0;

	assign lane_ok = (32'(in_ph) < 32'(eff_n)) && (32'(in_slot) < LANES_PER_PHASE);
	assign lane_we = acc_in && (in_op == wpa_pkg::OP_LANE) && lane_ok;
	assign lane_wa = LA_W'(32'(in_ph) * LANES_PER_PHASE + 32'(in_slot));
	assign lane_re = (state_q == wpa_pkg::ST_SCORE) && !sl_end;
	assign lane_ra = LA_W'(32'(ph_q) * LANES_PER_PHASE + 32'(sl_q));

	always_ff @(posedge clk) begin
		if (lane_we) begin
			lane_mem[lane_wa] <= {in_wait, in_queue};
		end
		if (lane_re) begin
			lane_rdata_q <= lane_mem[lane_ra];
		end
	end

	assign age_re  = (state_q == wpa_pkg::ST_AGE_RD) || ((state_q == wpa_pkg::ST_SCORE) && sl_end);
	assign age_cur = age_rvld_q ? age_rdata_q : '0;
	assign age_sum = (wpa_pkg::TIME_W + 1)'(age_cur) + (wpa_pkg::TIME_W + 1)'(age_dt_q);
	assign aged    = (age_sum > (wpa_pkg::TIME_W + 1)'(wpa_pkg::AGE_MAX)) ?
	                 wpa_pkg::AGE_MAX : age_sum[wpa_pkg::AGE_W-1:0];
	assign age_we  = (state_q == wpa_pkg::ST_AGE_WR) ||
	                 ((state_q == wpa_pkg::ST_FINISH) && (best_ph != act_q));
	assign age_wa  = (state_q == wpa_pkg::ST_AGE_WR) ? ph_q : best_ph;
	assign age_wd  = (state_q == wpa_pkg::ST_AGE_WR) ? aged : '0;

	always_ff @(posedge clk) begin
		if (age_we) begin
			age_mem[age_wa] <= age_wd;
		end
		if (age_re) begin
			age_rdata_q <= age_mem[ph_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_vld_q  <= '0;
			lane_rvld_q <= 1'b0;
			age_vld_q   <= '0;
			age_rvld_q  <= 1'b0;
		end else begin
			if (lane_we) begin
				lane_vld_q[lane_wa] <= 1'b1;
			end
			if (lane_re) begin
				lane_rvld_q <= lane_vld_q[lane_ra];
			end
			if (age_we) begin
				age_vld_q[age_wa] <= 1'b1;
			end
			if (age_re) begin
				age_rvld_q <= age_vld_q[ph_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld      <= (state_q == wpa_pkg::ST_SCORE);
			tag_s1.is_age   <= sl_end;
			tag_s1.final_ph <= sl_end && (ph_q == last_ph);
		end
	end

	always_ff @(posedge clk) begin
		ph_s1 <= ph_q;
	end

	assign queue_s1 = lane_rvld_q ? lane_rdata_q[wpa_pkg::QUEUE_W-1:0] : '0;
	assign wait_s1  = lane_rvld_q ? lane_rdata_q[LANE_DW-1:wpa_pkg::QUEUE_W] : '0;

	wpa_score #(
		.MAX_PHASES      (MAX_PHASES)
	) u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1),
		.ph_s1    (ph_s1),
		.queue_s1 (queue_s1),
		.wait_s1  (wait_s1),
		.age_s1   (age_cur),
		.queue_wt (qw_q),
		.wait_wt  (ww_q),
		.aging_wt (aw_q),
		.best_ph  (best_ph),
		.done     (score_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wpa_pkg::ST_IDLE;
			ph_q       <= '0;
			sl_q       <= '0;
			act_q      <= '0;
			now_q      <= '0;
			age_dt_q   <= '0;
			last_age_q <= '0;
			last_dec_q <= '0;
			decide_q   <= 1'b0;
			switched_q <= 1'b0;
			decided_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != wpa_pkg::ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				wpa_pkg::ST_IDLE: begin
					if (acc_in) begin
						switched_q <= 1'b0;
						decided_q  <= 1'b0;
						ph_q       <= '0;
						if (in_op == wpa_pkg::OP_LANE) begin
							state_q <= wpa_pkg::ST_DONE;
						end else begin
							now_q    <= in_time;
							age_dt_q <= (in_time > last_age_q) ? in_time - last_age_q : '0;
							if (in_time > last_age_q) begin
								last_age_q <= in_time;
							end
							decide_q <= (dur_q != '0) &&
							            (elapsed >= wpa_pkg::TIME_W'(dur_q));
							state_q  <= wpa_pkg::ST_AGE_RD;
						end
					end
				end
				wpa_pkg::ST_AGE_RD: begin
					state_q <= wpa_pkg::ST_AGE_WR;
				end
				wpa_pkg::ST_AGE_WR: begin
					if (ph_q == PH_W'(MAX_PHASES - 1)) begin
						ph_q    <= '0;
						sl_q    <= '0;
						state_q <= decide_q ? wpa_pkg::ST_SCORE : wpa_pkg::ST_DONE;
					end else begin
						ph_q    <= ph_q + PH_W'(1);
						state_q <= wpa_pkg::ST_AGE_RD;
					end
				end
				wpa_pkg::ST_SCORE: begin
					if (sl_end) begin
						sl_q <= '0;
						if (ph_q == last_ph) begin
							state_q <= wpa_pkg::ST_DRAIN;
						end else begin
							ph_q <= ph_q + PH_W'(1);
						end
					end else begin
						sl_q <= sl_q + SL_W'(1);
					end
				end
				wpa_pkg::ST_DRAIN: begin
					if (score_done) begin
						state_q <= wpa_pkg::ST_FINISH;
					end
				end
				wpa_pkg::ST_FINISH: begin
					decided_q  <= 1'b1;
					last_dec_q <= now_q;
					if (best_ph != act_q) begin
						act_q      <= best_ph;
						switched_q <= 1'b1;
					end
					state_q <= wpa_pkg::ST_DONE;
				end
				wpa_pkg::ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, decided_q, switched_q, wpa_pkg::OUT_PH_W'(act_q)};
						state_q    <= wpa_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= wpa_pkg::ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		score_done |-> (state_q == wpa_pkg::ST_DRAIN))
		else $error("score pass ended outside drain");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wpa_pkg::ST_FINISH) |=> $stable(act_q))
		else $error("active phase moved without a decision");

	a_switch_decided: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |-> m_tdata[4])
		else $error("switch reported without a decision");

	a_age_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wpa_pkg::ST_AGE_WR) |-> (32'(ph_q) < MAX_PHASES))
		else $error("age walk beyond last phase");
`endif

endmodule

[tb/sv/tb.sv]
module tb;

	localparam int N_PH = 8;
	localparam int N_LN = 4;
	localparam int WATCH_LIMIT = 5000;

	typedef struct {
		logic        op;
		logic [31:0] t;
		logic [2:0]  ph;
		logic [1:0]  slot;
		logic [7:0]  q;
		logic [15:0] w;
	} beat_t;

	typedef struct {
		logic [2:0] phase;
		logic       sw;
		logic       dec;
	} verdict_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [wpa_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [wpa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [63:0]                    s_tdata = '0;
	logic [0:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [7:0]                     m_tdata;

	weighted_phase_auction_with_aging_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #1 clk = ~clk;

	// auction state mirrored in the testbench
	logic [wpa_pkg::PIN_W-1:0]    pin_r = wpa_pkg::PHASES_RST;
	logic [wpa_pkg::WEIGHT_W-1:0] dur_r = wpa_pkg::DURATION_RST;
	logic [wpa_pkg::WEIGHT_W-1:0] qw_r = wpa_pkg::WEIGHT_RST;
	logic [wpa_pkg::WEIGHT_W-1:0] ww_r = wpa_pkg::WEIGHT_RST;
	logic [wpa_pkg::WEIGHT_W-1:0] aw_r = wpa_pkg::WEIGHT_RST;
	logic [wpa_pkg::QUEUE_W-1:0]  lane_q [N_PH*N_LN];
	logic [wpa_pkg::WAIT_W-1:0]   lane_w [N_PH*N_LN];
	logic [wpa_pkg::AGE_W-1:0]    age [N_PH];
	logic [2:0]                   cur_ph = '0;
	logic [wpa_pkg::TIME_W-1:0]   last_dec = '0;
	logic [wpa_pkg::TIME_W-1:0]   last_age = '0;

	beat_t       beat_queue [$];
	verdict_t    phase_expect [$];
	int          src_hold = 0;
	int          snk_hold = 0;
	bit          calm = 1'b0;
	bit          in_took = 1'b0;
	int          fails = 0;
	int          stuck = 0;
	int unsigned clock_s = 0;

	function automatic int unsigned active_count();
		if (pin_r == 0) return 1;
		if (32'(pin_r) > N_PH) return N_PH;
		return 32'(pin_r);
	endfunction

	function automatic longint unsigned phase_bid(int unsigned p);
		longint unsigned s;
		logic [4:0]      k;
		s = 0;
		for (int l = 0; l < N_LN; l++) begin
			k = 5'(p * N_LN + 32'(l));
			s += 64'(qw_r) * 64'(lane_q[k]);
			s += 64'(ww_r) * 64'(lane_w[k]);
		end
		s += 64'(aw_r) * 64'(age[3'(p)]);
		return s;
	endfunction

	function automatic verdict_t auction_step(beat_t b);
		verdict_t        v;
		logic [31:0]     span;
		longint unsigned sum;
		longint unsigned top;
		longint unsigned s;
		int unsigned     best;
		logic [4:0]      k;
		v.sw = 1'b0;
		v.dec = 1'b0;
		if (b.op == wpa_pkg::OP_LANE) begin
			if (32'(b.ph) < active_count() && 32'(b.slot) < N_LN) begin
				k = 5'(32'(b.ph) * N_LN + 32'(b.slot));
				lane_q[k] = b.q;
				lane_w[k] = b.w;
			end
		end else begin
			if (b.t > last_age) begin
				for (int i = 0; i < N_PH; i++) begin
					sum = 64'(age[3'(i)]) + 64'(b.t - last_age);
					age[3'(i)] = (sum > 64'(wpa_pkg::AGE_MAX)) ?
						wpa_pkg::AGE_MAX : sum[wpa_pkg::AGE_W-1:0];
				end
				last_age = b.t;
			end
			span = (b.t >= last_dec) ? b.t - last_dec : '0;
			if (dur_r != 0 && span >= 32'(dur_r)) begin
				best = 0;
				top = phase_bid(0);
				for (int unsigned p = 1; p < active_count(); p++) begin
					s = phase_bid(p);
					if (s > top) begin
						top = s;
						best = p;
					end
				end
				v.dec = 1'b1;
				if (3'(best) != cur_ph) begin
					cur_ph = best[2:0];
					age[3'(best)] = '0;
					v.sw = 1'b1;
				end
				last_dec = b.t;
			end
		end
		v.phase = cur_ph;
		return v;
	endfunction

	always @(negedge clk) begin
		beat_t b;
		if (arst_n && (!s_tvalid || in_took)) begin
			if (src_hold > 0) begin
				src_hold <= src_hold - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				src_hold <= $urandom_range(0, 5);
				s_tvalid <= 1'b0;
			end else if (beat_queue.size() > 0) begin
				b = beat_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, b.w, b.q, b.slot, b.ph, b.t};
				s_tuser <= b.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (snk_hold > 0) begin
			snk_hold <= snk_hold - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			snk_hold <= $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		verdict_t got;
		beat_t    b;
		in_took <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			got.phase = m_tdata[2:0];
			got.sw = m_tdata[3];
			got.dec = m_tdata[4];
			if (phase_expect.size() == 0) begin
				$display("%0t: result beat %h with nothing expected", $time, m_tdata);
				fails++;
			end else begin
				want = phase_expect.pop_front();
				if (got.phase !== want.phase) begin
					$display("%0t: current_phase expected %0d got %0d", $time, want.phase, got.phase);
					fails++;
				end
				if (got.sw !== want.sw) begin
					$display("%0t: switched expected %0d got %0d", $time, want.sw, got.sw);
					fails++;
				end
				if (got.dec !== want.dec) begin
					$display("%0t: decided expected %0d got %0d", $time, want.dec, got.dec);
					fails++;
				end
			end
		end
		if (s_tvalid && s_tready) begin
			b.op = s_tuser[0];
			b.t = s_tdata[31:0];
			b.ph = s_tdata[34:32];
			b.slot = s_tdata[36:35];
			b.q = s_tdata[44:37];
			b.w = s_tdata[60:45];
			phase_expect.push_back(auction_step(b));
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= WATCH_LIMIT) begin
			$display("weighted_phase_auction_with_aging_core verification failed");
			$finish;
		end
	end

	task automatic push_time(logic [31:0] t);
		beat_t b;
		b.op = wpa_pkg::OP_TIME;
		b.t = t;
		b.ph = 3'($urandom_range(0, 7));
		b.slot = 2'($urandom_range(0, 3));
		b.q = 8'($urandom);
		b.w = 16'($urandom);
		beat_queue.push_back(b);
	endtask

	task automatic push_lane(logic [2:0] ph, logic [1:0] slot, logic [7:0] q, logic [15:0] w);
		beat_t b;
		b.op = wpa_pkg::OP_LANE;
		b.t = $urandom;
		b.ph = ph;
		b.slot = slot;
		b.q = q;
		b.w = w;
		beat_queue.push_back(b);
	endtask

	task automatic settle();
		do @(posedge clk);
		while (beat_queue.size() != 0 || s_tvalid || phase_expect.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(wpa_pkg::cfg_reg_t r, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		case (r)
			wpa_pkg::REG_PHASES:   pin_r = v[wpa_pkg::PIN_W-1:0];
			wpa_pkg::REG_DURATION: dur_r = v;
			wpa_pkg::REG_QUEUE_WT: qw_r = v;
			wpa_pkg::REG_WAIT_WT:  ww_r = v;
			wpa_pkg::REG_AGING_WT: aw_r = v;
			default: ;
		endcase
	endtask

	task automatic configure(logic [3:0] pin, logic [15:0] dur, logic [15:0] qw,
			logic [15:0] ww, logic [15:0] aw);
		write_reg(wpa_pkg::REG_PHASES, {12'h000, pin});
		write_reg(wpa_pkg::REG_DURATION, dur);
		write_reg(wpa_pkg::REG_QUEUE_WT, qw);
		write_reg(wpa_pkg::REG_WAIT_WT, ww);
		write_reg(wpa_pkg::REG_AGING_WT, aw);
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return wpa_pkg::WEIGHT_RST;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_beat();
		int unsigned pick;
		logic [7:0]  q;
		logic [15:0] w;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			q = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) :
				8'($urandom);
			w = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) :
				16'($urandom_range(0, 600));
			if ($urandom_range(0, 3) == 0)
				w = 16'($urandom);
			push_lane(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), q, w);
		end else if (pick < 58) begin
			push_time(clock_s == 0 ? 0 : $urandom_range(0, clock_s - 1));
		end else if (pick < 59) begin
			clock_s += $urandom_range(32'h0080_0000, 32'h0180_0000);
			push_time(clock_s);
		end else begin
			clock_s += $urandom_range(0, 12);
			push_time(clock_s);
		end
	endtask

	initial begin
		foreach (lane_q[i]) begin
			lane_q[i] = '0;
			lane_w[i] = '0;
		end
		foreach (age[i])
			age[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_time(32'd0);
		push_lane(3'd3, 2'd2, 8'hFF, 16'hFFFF);
		push_lane(3'd7, 2'd3, 8'h00, 16'h0000);
		push_time(32'd10);
		push_time(32'd5);
		push_lane(3'd5, 2'd0, 8'hFF, 16'hFFFF);
		push_lane(3'd5, 2'd1, 8'hFF, 16'hFFFF);
		push_time(32'd20);
		push_time(32'd30);
		push_lane(3'd3, 2'd2, 8'h00, 16'h0000);
		push_lane(3'd5, 2'd0, 8'h00, 16'h0000);
		push_lane(3'd5, 2'd1, 8'h00, 16'h0000);
		push_time(32'd40);
		push_time(32'h0100_0028);
		push_time(32'h0100_0028);
		push_lane(3'd0, 2'd1, 8'h80, 16'h8000);
		push_time(32'h0100_0032);
		clock_s = 32'h0100_0032;
		settle();

		for (int k = 0; k < 10; k++) begin
			case (k)
				0: configure(4'd0, 16'd1, 16'hFFFF, 16'h0000, 16'hFFFF);
				1: configure(4'd15, 16'd0, 16'h0000, 16'hFFFF, 16'h0000);
				2: configure(4'd1, 16'hFFFF, wpa_pkg::WEIGHT_RST, wpa_pkg::WEIGHT_RST,
					wpa_pkg::WEIGHT_RST);
				3: configure(4'd8, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				4: configure(4'd2, 16'd5, wpa_pkg::WEIGHT_RST, 16'd1, 16'h0000);
				default: configure(4'($urandom_range(0, 15)),
					($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 20)),
					rand_weight(), rand_weight(), rand_weight());
			endcase
			if (k == 9) begin
				calm = 1'b1;
				clock_s = 32'hF000_0000 + $urandom_range(0, 32'h00FF_FFFF);
			end
			repeat (150) random_beat();
			if (k == 9)
				push_time(32'hFFFF_FFFF);
			settle();
		end

		repeat (80) @(posedge clk);
		if (fails == 0)
			$display("weighted_phase_auction_with_aging_core verification clean");
		else
			$display("weighted_phase_auction_with_aging_core verification failed");
		$finish;
	end

endmodule
